### rtl/core/smt_pkg.sv
package smt_pkg;

  // Table geometry.
  localparam int ROWS     = 32;
  localparam int COL_BITS = 12;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int CNT_W    = $clog2(ROWS + 1);

  // Fixed field widths of the channels and the register.
  localparam int FUNC_W  = 2;
  localparam int RIDX_W  = 8;
  localparam int KIND_W  = 2;
  localparam int MROW_W  = 5;
  localparam int RIU_W   = 6;
  localparam logic [RIU_W-1:0] RIU_RESET = RIU_W'(32);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET      = 2'd0,
    FUNC_UNSET    = 2'd1,
    FUNC_GREEDY   = 2'd2,
    FUNC_RESTRICT = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_OK    = 2'd0,
    KIND_ROW   = 2'd1,
    KIND_VIOL  = 2'd2,
    KIND_MATCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_COUNT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_op;
    logic rmw_exec;
    logic cnt_step;
    logic cnt_done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic row_emit;
    logic cnt_end;
  } stat_t;

endpackage

### rtl/core/smt_in_if.sv
interface smt_in_if import smt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [RIDX_W-1:0]   row;
  logic [COL_BITS-1:0] column;

  modport source (output valid, func, row, column, input ready);
  modport sink   (input valid, func, row, column, output ready);
endinterface

### rtl/core/smt_out_if.sv
interface smt_out_if import smt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [MROW_W-1:0]   match_row;
  logic [COL_BITS-1:0] match_col;
  logic                last;

  modport source (output valid, kind, match_row, match_col, last, input ready);
  modport sink   (input valid, kind, match_row, match_col, last, output ready);
endinterface

### rtl/core/smt_ctrl.sv
module smt_ctrl import smt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  input  stat_t             stat,
  output cmd_t              cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_op = 1'b1;
          if (func_t'(in_func) == FUNC_GREEDY || func_t'(in_func) == FUNC_RESTRICT) begin
            state_nxt = ST_COUNT;
          end else begin
            state_nxt = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        if (stat.slot_free) begin
          cmd.rmw_exec = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_COUNT: begin
        if (stat.cnt_end) begin
          if (stat.slot_free) begin
            cmd.cnt_done = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (!stat.row_emit || stat.slot_free) begin
          cmd.cnt_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/smt_dp.sv
module smt_dp import smt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [RIU_W-1:0]    cfg_wr_data,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [RIDX_W-1:0]   in_row,
  input  logic [COL_BITS-1:0] in_column,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [KIND_W-1:0]   out_kind,
  output logic [MROW_W-1:0]   out_match_row,
  output logic [COL_BITS-1:0] out_match_col,
  output logic                out_last
);

  // Run storage: one start and one end column per row, read through a register.
  logic [COL_BITS-1:0] start_mem [ROWS];
  logic [COL_BITS-1:0] end_mem   [ROWS];
  logic [COL_BITS-1:0] rd_start_r, rd_end_r;
  logic [ROWS-1:0]     filled_r, filled_nxt;

  logic [RIU_W-1:0]    rows_r;
  func_t               op_func_r;
  logic [RIDX_W-1:0]   op_row_r;
  logic [COL_BITS-1:0] op_col_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [COL_BITS:0]   next_min_r, next_min_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               kind_r, kind_nxt;
  logic [MROW_W-1:0]   mrow_r, mrow_nxt;
  logic [COL_BITS-1:0] mcol_r, mcol_nxt;
  logic                last_r, last_nxt;

  logic [RIU_W-1:0]    lim;
  logic                rd_en;
  logic [ROW_W-1:0]    rd_addr;
  logic                wr_en;
  logic [COL_BITS-1:0] wr_start, wr_end;
  logic [ROW_W-1:0]    op_idx;
  logic [ROW_W-1:0]    cnt_idx;
  logic [COL_BITS:0]   s_x, e_x, c_x, cand;
  logic                in_range;
  logic                row_emit;
  kind_t               rmw_kind;

  // Rows actually in use, capped at the table size.
  assign lim = (rows_r > RIU_W'(ROWS)) ? RIU_W'(ROWS) : rows_r;

  // Row-limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RIU_RESET;
    end else if (cfg_wr_en) begin
      rows_r <= cfg_wr_data;
    end
  end

  // Latch the operation on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.ld_op) begin
      op_func_r <= func_t'(in_func);
      op_row_r  <= in_row;
      op_col_r  <= in_column;
    end
  end

  // Read port: addressed row (row 0 for counts) on accept, next row while counting.
  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(1);
    rd_en   = cmd.ld_op || cmd.cnt_step;
    if (cmd.ld_op) begin
      if (func_t'(in_func) == FUNC_SET || func_t'(in_func) == FUNC_UNSET) begin
        rd_addr = in_row[ROW_W-1:0];
      end else begin
        rd_addr = '0;
      end
    end else begin
      rd_addr = cnt_nxt[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start_r <= start_mem[rd_addr];
      rd_end_r   <= end_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[op_idx] <= wr_start;
      end_mem[op_idx]   <= wr_end;
    end
  end

  // Shared operands, widened by one bit so that start minus one and end plus one fit.
  assign s_x      = {1'b0, rd_start_r};
  assign e_x      = {1'b0, rd_end_r};
  assign c_x      = {1'b0, op_col_r};
  assign op_idx   = op_row_r[ROW_W-1:0];
  assign cnt_idx  = cnt_r[ROW_W-1:0];
  assign in_range = op_row_r < RIDX_W'(lim);

  // Set and unset: one read-modify-write of the addressed row.
  always_comb begin
    filled_nxt = filled_r;
    wr_en      = 1'b0;
    wr_start   = rd_start_r;
    wr_end     = rd_end_r;
    rmw_kind   = KIND_OK;
    if (!in_range) begin
      rmw_kind = KIND_ROW;
    end else if (op_func_r == FUNC_SET) begin
      if (!filled_r[op_idx]) begin
        filled_nxt[op_idx] = cmd.rmw_exec;
        wr_en              = cmd.rmw_exec;
        wr_start           = op_col_r;
        wr_end             = op_col_r;
      end else if ((c_x + 1'b1 < s_x) || (c_x > e_x + 1'b1)) begin
        rmw_kind = KIND_VIOL;
      end else begin
        wr_en    = cmd.rmw_exec;
        wr_start = (c_x < s_x) ? op_col_r : rd_start_r;
        wr_end   = (c_x > e_x) ? op_col_r : rd_end_r;
      end
    end else if (filled_r[op_idx]) begin
      if ((c_x > s_x) && (c_x < e_x)) begin
        rmw_kind = KIND_VIOL;
      end else if ((c_x == s_x) && (c_x == e_x)) begin
        // The last column of the run goes away: the row becomes empty.
        if (cmd.rmw_exec) begin
          filled_nxt[op_idx] = 1'b0;
        end
      end else begin
        wr_en    = cmd.rmw_exec;
        wr_start = (c_x == s_x) ? rd_start_r + 1'b1 : rd_start_r;
        wr_end   = (c_x == e_x) ? rd_end_r - 1'b1 : rd_end_r;
      end
    end
  end

  // Count: candidate column of the current row and whether it is emitted.
  always_comb begin
    cand = (s_x > next_min_r) ? s_x : next_min_r;
    if (!filled_r[cnt_idx]) begin
      row_emit = 1'b0;
    end else if (op_func_r == FUNC_RESTRICT) begin
      row_emit = (s_x == e_x) && (s_x >= next_min_r);
    end else begin
      row_emit = cand <= e_x;
    end
  end

  // Row walk counter and the least column the next match may take.
  always_ff @(posedge clk) begin
    if (cmd.ld_op) begin
      cnt_r      <= '0;
      next_min_r <= '0;
    end else if (cmd.cnt_step) begin
      cnt_r      <= cnt_nxt;
      next_min_r <= next_min_nxt;
    end
  end

  assign next_min_nxt = row_emit ? cand + 1'b1 : next_min_r;

  // Row occupancy flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
    end else begin
      filled_r <= filled_nxt;
    end
  end

  // Output register: loaded when a result is produced, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    mrow_nxt      = mrow_r;
    mcol_nxt      = mcol_r;
    last_nxt      = last_r;
    if (cmd.rmw_exec) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = rmw_kind;
      mrow_nxt      = '0;
      mcol_nxt      = '0;
      last_nxt      = 1'b1;
    end else if (cmd.cnt_done) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_OK;
      mrow_nxt      = '0;
      mcol_nxt      = '0;
      last_nxt      = 1'b1;
    end else if (cmd.cnt_step && row_emit) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_MATCH;
      mrow_nxt      = MROW_W'(cnt_r);
      mcol_nxt      = cand[COL_BITS-1:0];
      last_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    mrow_r <= mrow_nxt;
    mcol_r <= mcol_nxt;
    last_r <= last_nxt;
  end

  // Status to the controller.
  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.row_emit  = row_emit;
  assign stat.cnt_end   = cnt_r == CNT_W'(lim);

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_match_row = mrow_r;
  assign out_match_col = mcol_r;
  assign out_last      = last_r;

endmodule

### rtl/core/staircase_match_table.sv
// Set and unset: the item's row is read on acceptance, and its single result is loaded
// from the read-modify-write state into the output register once that register is free.
// Counts walk one row per cycle through the run memory's registered read port, holding
// while a match or the done result waits on a stalled output, and end with a done result.
// The next item is accepted once the current one has produced its last result.
// Reset (synchronous, active low) empties every row and sets rows in use to 32;
// the run memory itself is not cleared, so no clearing pass is needed.
module staircase_match_table import smt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [RIU_W-1:0] cfg_wr_data,
  smt_in_if.sink           in_ch,
  smt_out_if.source        out_ch
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer for the operations.
  smt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Run storage, compare logic and output register.
  smt_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_func       (in_ch.func),
    .in_row        (in_ch.row),
    .in_column     (in_ch.column),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_kind      (out_ch.kind),
    .out_match_row (out_ch.match_row),
    .out_match_col (out_ch.match_col),
    .out_last      (out_ch.last)
  );

endmodule

### tb/staircase_match_table_tb.sv
module staircase_match_table_tb;
  import smt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int NOISE_PCT    = 15;
  localparam int PHASE_ITEMS  = 50;
  localparam int QUIET_ITEMS  = 40;
  localparam int MAX_REPORTS  = 200;

  typedef struct packed {
    kind_t               kind;
    logic [MROW_W-1:0]   mrow;
    logic [COL_BITS-1:0] mcol;
    logic                last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [RIU_W-1:0] cfg_wr_data;

  smt_in_if  in_ch ();
  smt_out_if out_ch ();

  staircase_match_table dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Shadow copy of the table and its row limit.
  logic [COL_BITS-1:0] run_lo [ROWS];
  logic [COL_BITS-1:0] run_hi [ROWS];
  bit                  run_full [ROWS];
  logic [RIU_W-1:0]    rows_limit;

  result_t pending_results [$];
  int      error_count;
  int      cycle_count;
  bit      idle_on;
  bit      hold_req;
  logic    receiver_hold;

  always #1 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < MAX_REPORTS) begin
      $display("MISMATCH at cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  function automatic void queue_result(kind_t k, int r, int c, logic lst);
    result_t res;
    res.kind = k;
    res.mrow = MROW_W'(r);
    res.mcol = COL_BITS'(c);
    res.last = lst;
    pending_results.push_back(res);
  endfunction

  function automatic int active_rows();
    return (rows_limit > ROWS) ? ROWS : int'(rows_limit);
  endfunction

  // Apply one accepted item to the shadow table and queue the results it causes.
  function automatic void predict_table_op(func_t f, logic [RIDX_W-1:0] r,
                                           logic [COL_BITS-1:0] c);
    int    act;
    int    s;
    int    e;
    int    col;
    int    last_hit;
    int    cand;
    kind_t k;
    act = active_rows();
    col = c;
    case (f)
      FUNC_SET, FUNC_UNSET: begin
        k = KIND_OK;
        if (r >= act) begin
          k = KIND_ROW;
        end else if (f == FUNC_SET) begin
          if (!run_full[r]) begin
            run_full[r] = 1'b1;
            run_lo[r] = c;
            run_hi[r] = c;
          end else begin
            s = run_lo[r];
            e = run_hi[r];
            // The column must touch the run or lie inside it.
            if (col < s - 1 || col > e + 1) begin
              k = KIND_VIOL;
            end else begin
              if (col < s) run_lo[r] = c;
              if (col > e) run_hi[r] = c;
            end
          end
        end else if (run_full[r]) begin
          s = run_lo[r];
          e = run_hi[r];
          // Only the ends of the run can be trimmed.
          if (col > s && col < e) begin
            k = KIND_VIOL;
          end else begin
            if (s == col) s++;
            if (e == col) e--;
            if (s > e) begin
              run_full[r] = 1'b0;
              run_lo[r] = '0;
              run_hi[r] = '0;
            end else begin
              run_lo[r] = COL_BITS'(s);
              run_hi[r] = COL_BITS'(e);
            end
          end
        end
        queue_result(k, 0, 0, 1'b1);
      end
      default: begin
        last_hit = -1;
        for (int i = 0; i < act; i++) begin
          if (!run_full[i]) continue;
          s = run_lo[i];
          e = run_hi[i];
          if (f == FUNC_RESTRICT) begin
            if (s != e || s <= last_hit) continue;
            cand = s;
          end else begin
            cand = (s > last_hit + 1) ? s : last_hit + 1;
            if (cand > e) continue;
          end
          last_hit = cand;
          queue_result(KIND_MATCH, i, cand, 1'b0);
        end
        queue_result(KIND_OK, 0, 0, 1'b1);
      end
    endcase
  endfunction

  // Offer one item, wait for its handshake and predict its results.
  // Valid stays high afterwards; a drain lowers it, and the next call sometimes does.
  task automatic send_item(func_t f, logic [RIDX_W-1:0] r, logic [COL_BITS-1:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.row    <= r;
    in_ch.column <= c;
    do @(posedge clk); while (!in_ch.ready);
    predict_table_op(f, r, c);
  endtask

  // Lower valid and wait on the clock until every expected result is taken.
  task automatic wait_table_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_rows_in_use(logic [RIU_W-1:0] v);
    wait_table_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rows_limit = v;
  endtask

  // Mostly runs that grow and shrink at their ends, with counts and some noise.
  task automatic send_random_item();
    int                  act;
    int                  pick;
    func_t               f;
    logic [RIDX_W-1:0]   r;
    logic [COL_BITS-1:0] c;
    logic [COL_BITS-1:0] s;
    logic [COL_BITS-1:0] e;
    act  = active_rows();
    pick = $urandom_range(0, 99);
    r = RIDX_W'($urandom_range(0, 255));
    c = COL_BITS'($urandom_range(0, 4095));
    if (pick < 10) begin
      f = ($urandom_range(0, 1) != 0) ? FUNC_GREEDY : FUNC_RESTRICT;
    end else if (pick < 10 + NOISE_PCT || act == 0) begin
      f = ($urandom_range(0, 1) != 0) ? FUNC_UNSET : FUNC_SET;
    end else begin
      r = RIDX_W'($urandom_range(0, act - 1));
      if (!run_full[r]) begin
        f = FUNC_SET;
        // New runs mostly start on a rising staircase.
        if ($urandom_range(0, 9) != 0) c = COL_BITS'(r * 96 + $urandom_range(0, 80));
      end else begin
        s = run_lo[r];
        e = run_hi[r];
        case ($urandom_range(0, 5))
          0: begin f = FUNC_SET;   c = s - 1'b1; end
          1: begin f = FUNC_SET;   c = e + 1'b1; end
          2: begin f = FUNC_UNSET; c = s; end
          3: begin f = FUNC_UNSET; c = e; end
          4: begin f = FUNC_SET;   c = COL_BITS'($urandom_range(s, e)); end
          default: begin f = FUNC_UNSET; c = COL_BITS'($urandom_range(s, e)); end
        endcase
      end
    end
    send_item(f, r, c);
  endtask

  // Counts and unsets on an empty table, and rows beyond the limit.
  task automatic test_empty_table();
    send_item(FUNC_GREEDY, 8'd0, 12'd0);
    send_item(FUNC_RESTRICT, 8'd0, 12'd0);
    send_item(FUNC_UNSET, 8'd3, 12'd5);
    send_item(FUNC_SET, 8'd255, 12'd4095);
    send_item(FUNC_SET, 8'd32, 12'd0);
  endtask

  // Growing and trimming runs at the column extremes, with violations.
  task automatic test_run_edges();
    send_item(FUNC_SET, 8'd0, 12'd0);
    send_item(FUNC_SET, 8'd0, 12'd1);
    send_item(FUNC_SET, 8'd0, 12'd3);
    send_item(FUNC_SET, 8'd0, 12'd2);
    send_item(FUNC_UNSET, 8'd0, 12'd1);
    send_item(FUNC_UNSET, 8'd0, 12'd100);
    send_item(FUNC_SET, 8'd31, 12'd4095);
    send_item(FUNC_SET, 8'd31, 12'd4094);
    send_item(FUNC_SET, 8'd31, 12'd4092);
    send_item(FUNC_UNSET, 8'd31, 12'd4095);
    send_item(FUNC_UNSET, 8'd31, 12'd4094);
  endtask

  // Both counts over a small table with single-column and wider runs.
  task automatic test_counts();
    send_item(FUNC_SET, 8'd1, 12'd10);
    send_item(FUNC_SET, 8'd2, 12'd10);
    send_item(FUNC_SET, 8'd2, 12'd11);
    send_item(FUNC_GREEDY, 8'd0, 12'd0);
    send_item(FUNC_RESTRICT, 8'd0, 12'd0);
  endtask

  // Row limit at zero, one, beyond the table size, and back to full.
  task automatic test_row_limit();
    write_rows_in_use(6'd0);
    send_item(FUNC_SET, 8'd0, 12'd0);
    send_item(FUNC_GREEDY, 8'd0, 12'd0);
    write_rows_in_use(6'd1);
    send_item(FUNC_GREEDY, 8'd0, 12'd0);
    send_item(FUNC_SET, 8'd1, 12'd20);
    write_rows_in_use(6'd63);
    send_item(FUNC_SET, 8'd31, 12'd7);
    send_item(FUNC_RESTRICT, 8'd0, 12'd0);
    write_rows_in_use(6'd32);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_random_item();
    wait_table_idle();
    idle_on = 1'b1;
  endtask

  // Random phases under several row limits.
  task automatic test_random_phases();
    int limits [6];
    limits = '{32, 5, 17, 63, 1, 24};
    foreach (limits[i]) begin
      write_rows_in_use(RIU_W'(limits[i]));
      repeat (PHASE_ITEMS) send_random_item();
    end
  endtask

  // Full rate on both sides to finish.
  task automatic test_full_rate();
    write_rows_in_use(6'd32);
    idle_on = 1'b0;
    repeat (QUIET_ITEMS) send_random_item();
  endtask

  // Result sink: random stall bursts plus the long hold-off.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_hold) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 18);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Long hold-off on the result side, counted here.
  initial begin : hold_off
    receiver_hold <= 1'b0;
    wait (hold_req);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, kind", out_ch.kind, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind != want.kind) report_mismatch("kind", out_ch.kind, want.kind);
        if (out_ch.match_row != want.mrow)
          report_mismatch("match_row", out_ch.match_row, want.mrow);
        if (out_ch.match_col != want.mcol)
          report_mismatch("match_col", out_ch.match_col, want.mcol);
        if (out_ch.last != want.last) report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  initial begin
    error_count  = 0;
    cycle_count  = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    rows_limit   = RIU_RESET;
    foreach (run_full[i]) begin
      run_full[i] = 1'b0;
      run_lo[i] = '0;
      run_hi[i] = '0;
    end
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= '0;
    in_ch.row    <= '0;
    in_ch.column <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_run_edges();
    test_counts();
    test_row_limit();
    test_backpressure();
    test_random_phases();
    test_full_rate();

    // Drain, then give the block time to show any stray result.
    wait_table_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results still expected", 0, pending_results.size());
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
